// File: design/ehr_pkg.sv
// shared widths, constants and register codes for the ellipsoid height core
`default_nettype none

package ehr_pkg;

    // item and register field widths
    localparam int DIST_W      = 40;
    localparam int LAT_W       = 32;
    localparam int HEIGHT_W    = 41;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 40;

    // q30 angle and series values
    localparam int ANG_W = 31;
    localparam int X2_W  = 32;
    localparam logic [ANG_W-1:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [ANG_W-1:0] HALF_PI_Q30 = 31'd1686629713;
    localparam int SERIES_TERMS = 9;

    // square root and divider geometry
    localparam int ROOT_STEPS = 62;
    localparam int ROOT_W     = 124;
    localparam int NORM_W     = 62;
    localparam int QUOT_W     = 42;
    localparam int DIV_REM_W  = 104;
    localparam logic [QUOT_W-1:0] RADIUS_CAP = 42'h200_0000_0000;

    // reset values of the radius registers
    localparam logic [CFG_DATA_W-1:0] EQUATORIAL_RESET = 40'd6531212288;
    localparam logic [CFG_DATA_W-1:0] POLAR_RESET      = 40'd6509314370;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_EQUATORIAL = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_POLAR      = 1'b1;

endpackage

`default_nettype wire

// File: design/ehr_mul.sv
// two-stage pipelined multiplier built from 32 by 32 partial products
`default_nettype none

module ehr_mul #(
    parameter int AW = 32,
    parameter int BW = 32,
    parameter int SW = 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_v,
    input  wire logic [AW-1:0] a,
    input  wire logic [BW-1:0] b,
    input  wire logic [SW-1:0] side_in,
    output logic               out_v,
    output logic [AW+BW-1:0]   p,
    output logic [SW-1:0]      side_out
);

    localparam int CW   = 32;
    localparam int NA   = (AW + CW - 1) / CW;
    localparam int NB   = (BW + CW - 1) / CW;
    localparam int SUMW = (NA + NB) * CW;
    localparam int PW   = AW + BW;

    logic [NA*CW-1:0] a_pad;
    logic [NB*CW-1:0] b_pad;
    logic [2*CW-1:0]  pp_reg [NA][NB];
    logic             v1_reg;
    logic [SW-1:0]    side1_reg;
    logic             v2_reg;
    logic [PW-1:0]    p_reg;
    logic [SW-1:0]    side2_reg;
    logic [SUMW-1:0]  sum_next;

    assign a_pad = (NA*CW)'(a);
    assign b_pad = (NB*CW)'(b);

    // sum of the shifted partial products
    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                sum_next = sum_next + (SUMW'(pp_reg[i][j]) << (CW * (i + j)));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_v;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NA; i++)
            begin
                for (int j = 0; j < NB; j++)
                begin
                    pp_reg[i][j] <= a_pad[i*CW +: CW] * b_pad[j*CW +: CW];
                end
            end
            side1_reg <= side_in;
            p_reg     <= sum_next[PW-1:0];
            side2_reg <= side1_reg;
        end
    end

    assign out_v    = v2_reg;
    assign p        = p_reg;
    assign side_out = side2_reg;

endmodule

`default_nettype wire

// File: design/ehr_horner_cell.sv
// one horner step of the sine and cosine series, three stages deep
`default_nettype none

module ehr_horner_cell #(
    parameter int K  = 1,
    parameter int SW = 1
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       in_v,
    input  wire logic [ehr_pkg::X2_W-1:0]   x2_in,
    input  wire logic [ehr_pkg::ANG_W-1:0]  tc_in,
    input  wire logic [ehr_pkg::ANG_W-1:0]  ts_in,
    input  wire logic [SW-1:0]              side_in,
    output logic                            out_v,
    output logic [ehr_pkg::X2_W-1:0]        x2_out,
    output logic [ehr_pkg::ANG_W-1:0]       tc_out,
    output logic [ehr_pkg::ANG_W-1:0]       ts_out,
    output logic [SW-1:0]                   side_out
);

    localparam int unsigned DCos = (2 * K - 1) * (2 * K);
    localparam int unsigned DSin = (2 * K) * (2 * K + 1);
    localparam logic [63:0] RecipCosW = (64'd1 << 33) / 64'(DCos);
    localparam logic [63:0] RecipSinW = (64'd1 << 33) / 64'(DSin);
    localparam logic [32:0] RecipCos  = RecipCosW[32:0];
    localparam logic [32:0] RecipSin  = RecipSinW[32:0];

    // quotient estimate is low by at most one, fix it with one compare
    function automatic logic [ehr_pkg::ANG_W-1:0] term_next(
        input logic [32:0] u,
        input logic [65:0] est,
        input logic [8:0]  d
    );
        logic [32:0] q;
        logic [41:0] r;
        logic [33:0] v;
        q = est[65:33];
        r = 42'(u) - 42'(q) * 42'(d);
        v = 34'(q) + ((r >= 42'(d)) ? 34'd1 : 34'd0);
        return (v > 34'(ehr_pkg::ONE_Q30)) ? '0 : 31'(34'(ehr_pkg::ONE_Q30) - v);
    endfunction

    logic                      v1_reg, v2_reg, v3_reg;
    logic [ehr_pkg::X2_W-1:0]  x2_1_reg, x2_2_reg, x2_3_reg;
    logic [SW-1:0]             side1_reg, side2_reg, side3_reg;
    logic [62:0]               yc1_reg, ys1_reg;
    logic [32:0]               uc2_reg, us2_reg;
    logic [65:0]               ec2_reg, es2_reg;
    logic [ehr_pkg::ANG_W-1:0] tc3_reg, ts3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_v;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // product with the running term
            x2_1_reg  <= x2_in;
            side1_reg <= side_in;
            yc1_reg   <= 63'(x2_in) * 63'(tc_in);
            ys1_reg   <= 63'(x2_in) * 63'(ts_in);
            // reciprocal multiply
            x2_2_reg  <= x2_1_reg;
            side2_reg <= side1_reg;
            uc2_reg   <= yc1_reg[62:30];
            us2_reg   <= ys1_reg[62:30];
            ec2_reg   <= 66'(yc1_reg[62:30]) * 66'(RecipCos);
            es2_reg   <= 66'(ys1_reg[62:30]) * 66'(RecipSin);
            // correction and new term
            x2_3_reg  <= x2_2_reg;
            side3_reg <= side2_reg;
            tc3_reg   <= term_next(uc2_reg, ec2_reg, 9'(DCos));
            ts3_reg   <= term_next(us2_reg, es2_reg, 9'(DSin));
        end
    end

    assign out_v    = v3_reg;
    assign x2_out   = x2_3_reg;
    assign tc_out   = tc3_reg;
    assign ts_out   = ts3_reg;
    assign side_out = side3_reg;

endmodule

`default_nettype wire

// File: design/ehr_root_cell.sv
// one digit step of the integer square root
`default_nettype none

module ehr_root_cell #(
    parameter int BITPOS = 0,
    parameter int SW     = 1
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_v,
    input  wire logic [ehr_pkg::ROOT_W-1:0]  rem_in,
    input  wire logic [ehr_pkg::ROOT_W-1:0]  root_in,
    input  wire logic [SW-1:0]               side_in,
    output logic                             out_v,
    output logic [ehr_pkg::ROOT_W-1:0]       rem_out,
    output logic [ehr_pkg::ROOT_W-1:0]       root_out,
    output logic [SW-1:0]                    side_out
);

    localparam logic [ehr_pkg::ROOT_W-1:0] Bit = ehr_pkg::ROOT_W'(1) << (2 * BITPOS);

    logic [ehr_pkg::ROOT_W-1:0] trial;
    logic [ehr_pkg::ROOT_W-1:0] rem_next, root_next;
    logic                       v_reg;
    logic [ehr_pkg::ROOT_W-1:0] rem_reg, root_reg;
    logic [SW-1:0]              side_reg;

    always_comb
    begin
        trial = root_in + Bit;
        if (rem_in >= trial)
        begin
            rem_next  = rem_in - trial;
            root_next = (root_in >> 1) + Bit;
        end
        else
        begin
            rem_next  = rem_in;
            root_next = root_in >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

    assign out_v    = v_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign side_out = side_reg;

endmodule

`default_nettype wire

// File: design/ehr_div_cell.sv
// one quotient bit of the restoring divider
`default_nettype none

module ehr_div_cell #(
    parameter int J  = 0,
    parameter int SW = 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_v,
    input  wire logic [ehr_pkg::DIV_REM_W-1:0] rem_in,
    input  wire logic [ehr_pkg::NORM_W-1:0]    d_in,
    input  wire logic [ehr_pkg::QUOT_W-1:0]    q_in,
    input  wire logic [SW-1:0]                 side_in,
    output logic                               out_v,
    output logic [ehr_pkg::DIV_REM_W-1:0]      rem_out,
    output logic [ehr_pkg::NORM_W-1:0]         d_out,
    output logic [ehr_pkg::QUOT_W-1:0]         q_out,
    output logic [SW-1:0]                      side_out
);

    localparam logic [ehr_pkg::QUOT_W-1:0] QBit = ehr_pkg::QUOT_W'(1) << J;

    logic [ehr_pkg::DIV_REM_W-1:0] dsh;
    logic [ehr_pkg::DIV_REM_W-1:0] rem_next;
    logic [ehr_pkg::QUOT_W-1:0]    q_next;
    logic                          v_reg;
    logic [ehr_pkg::DIV_REM_W-1:0] rem_reg;
    logic [ehr_pkg::NORM_W-1:0]    d_reg;
    logic [ehr_pkg::QUOT_W-1:0]    q_reg;
    logic [SW-1:0]                 side_reg;

    always_comb
    begin
        dsh = ehr_pkg::DIV_REM_W'(d_in) << J;
        if (rem_in >= dsh)
        begin
            rem_next = rem_in - dsh;
            q_next   = q_in | QBit;
        end
        else
        begin
            rem_next = rem_in;
            q_next   = q_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            d_reg    <= d_in;
            q_reg    <= q_next;
            side_reg <= side_in;
        end
    end

    assign out_v    = v_reg;
    assign rem_out  = rem_reg;
    assign d_out    = d_reg;
    assign q_out    = q_reg;
    assign side_out = side_reg;

endmodule

`default_nettype wire

// File: design/ellipsoid_height_from_radius_core.sv
// top level of the ellipsoid height core: input clamp, series, root, divide, output skid
`default_nettype none

// Height above the reference ellipsoid. Each item carries a distance from the planet
// center (unsigned, 1/1024 m) and a geocentric latitude (signed radians in Q30, clamped
// to +-pi/2); the result is distance minus the ellipsoid radius
// P*E / sqrt((E*sin)^2 + (P*cos)^2), saturated to +-(2^40 - 1). The core is one long
// pipeline that takes a new item every cycle while in_stall is low and returns one
// result per item, in order. The pipeline holds 9 horner cells of 3 stages for
// sine and cosine, 62 square-root cells and 42 divider cells of one stage each,
// plus seven 2-stage multipliers. A stalled output holds one result in the output
// register and one more in a skid register; only when both are full is input stalled.
// A zero norm (both radius terms zero) gives a radius of zero. The radius registers are
// written through cfg_write / cfg_index / cfg_data and must not change while items are
// in flight.

module ellipsoid_height_from_radius_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [ehr_pkg::DIST_W-1:0]         center_distance,
    input  wire logic signed [ehr_pkg::LAT_W-1:0]   geo_latitude,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [ehr_pkg::HEIGHT_W-1:0]     ellipsoid_height,
    input  wire logic                               cfg_write,
    input  wire logic [ehr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [ehr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int DW    = ehr_pkg::DIST_W;
    localparam int AW    = ehr_pkg::ANG_W;
    localparam int TERMS = ehr_pkg::SERIES_TERMS;
    localparam int STEPS = ehr_pkg::ROOT_STEPS;
    localparam int QW    = ehr_pkg::QUOT_W;
    localparam int RW    = ehr_pkg::CFG_DATA_W;
    localparam int HW    = ehr_pkg::HEIGHT_W;
    localparam int AB_W  = RW + AW - 10;   // radius term width, 61
    localparam int SQ_W  = 2 * AB_W;       // squared term width, 122
    localparam int N_W   = SQ_W + 1;       // sum of squares, 123
    localparam int PE_W  = 2 * RW;         // radius product, 80

    localparam int SIDE_DX  = DW + AW;
    localparam int SIDE_DA  = DW + AB_W;
    localparam int SIDE_DS  = DW + SQ_W;
    localparam int SIDE_DN  = DW + N_W;
    localparam int SIDE_DP  = DW + PE_W;
    localparam int SIDE_DIV = DW + 2;

    localparam logic signed [HW+1:0] NegLimit = -43'sd1099511627775;
    localparam logic signed [HW+1:0] PosLimit = 43'sd1099511627775;

    // radius registers
    logic [RW-1:0] equatorial_radius_reg;
    logic [RW-1:0] polar_radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            equatorial_radius_reg <= ehr_pkg::EQUATORIAL_RESET;
            polar_radius_reg      <= ehr_pkg::POLAR_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ehr_pkg::REG_EQUATORIAL: equatorial_radius_reg <= cfg_data;
                ehr_pkg::REG_POLAR:      polar_radius_reg      <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // whole pipeline moves unless the skid register is holding a result
    logic advance;
    logic skid_valid_reg;
    assign advance  = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    // input stage: absolute latitude, clamped to pi/2
    logic [ehr_pkg::LAT_W-1:0] lat_bits, lat_mag;
    logic [AW-1:0]             x_next;
    logic                      s0_v_reg;
    logic [DW-1:0]             s0_dist_reg;
    logic [AW-1:0]             s0_x_reg;

    always_comb
    begin
        lat_bits = geo_latitude;
        lat_mag  = lat_bits[ehr_pkg::LAT_W-1] ? (ehr_pkg::LAT_W'(0) - lat_bits) : lat_bits;
        x_next   = (lat_mag > ehr_pkg::LAT_W'(ehr_pkg::HALF_PI_Q30)) ?
                   ehr_pkg::HALF_PI_Q30 : lat_mag[AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            s0_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_dist_reg <= center_distance;
            s0_x_reg    <= x_next;
        end
    end

    // x squared in q30
    logic               m1_v;
    logic [2*AW-1:0]    m1_p;
    logic [SIDE_DX-1:0] m1_side;

    ehr_mul #(.AW(AW), .BW(AW), .SW(SIDE_DX)) u_mul_x2 (
        .clk(clk), .rst_n(rst_n), .en(advance), .in_v(s0_v_reg),
        .a(s0_x_reg), .b(s0_x_reg), .side_in({s0_dist_reg, s0_x_reg}),
        .out_v(m1_v), .p(m1_p), .side_out(m1_side)
    );

    // horner row, highest term first; side carries distance and x
    logic                     hv    [TERMS+1];
    logic [ehr_pkg::X2_W-1:0] hx2   [TERMS+1];
    logic [AW-1:0]            htc   [TERMS+1];
    logic [AW-1:0]            hts   [TERMS+1];
    logic [SIDE_DX-1:0]       hside [TERMS+1];

    assign hv[0]    = m1_v;
    assign hx2[0]   = m1_p[2*AW-1:30];
    assign htc[0]   = ehr_pkg::ONE_Q30;
    assign hts[0]   = ehr_pkg::ONE_Q30;
    assign hside[0] = m1_side;

    for (genvar i = 0; i < TERMS; i++)
    begin : g_horner
        ehr_horner_cell #(.K(TERMS - i), .SW(SIDE_DX)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(advance), .in_v(hv[i]),
            .x2_in(hx2[i]), .tc_in(htc[i]), .ts_in(hts[i]), .side_in(hside[i]),
            .out_v(hv[i+1]), .x2_out(hx2[i+1]), .tc_out(htc[i+1]), .ts_out(hts[i+1]),
            .side_out(hside[i+1])
        );
    end

    // sine = x * odd series; side now carries distance and cosine
    logic               m2_v;
    logic [2*AW-1:0]    m2_p;
    logic [SIDE_DX-1:0] m2_side;

    ehr_mul #(.AW(AW), .BW(AW), .SW(SIDE_DX)) u_mul_sin (
        .clk(clk), .rst_n(rst_n), .en(advance), .in_v(hv[TERMS]),
        .a(hside[TERMS][AW-1:0]), .b(hts[TERMS]),
        .side_in({hside[TERMS][SIDE_DX-1:AW], htc[TERMS]}),
        .out_v(m2_v), .p(m2_p), .side_out(m2_side)
    );

    // a = e * sin
    logic               m3_v;
    logic [RW+AW-1:0]   m3_p;
    logic [SIDE_DX-1:0] m3_side;

    ehr_mul #(.AW(RW), .BW(AW), .SW(SIDE_DX)) u_mul_a (
        .clk(clk), .rst_n(rst_n), .en(advance), .in_v(m2_v),
        .a(equatorial_radius_reg), .b(m2_p[2*AW-2:30]), .side_in(m2_side),
        .out_v(m3_v), .p(m3_p), .side_out(m3_side)
    );

    // b = p * cos
    logic               m4_v;
    logic [RW+AW-1:0]   m4_p;
    logic [SIDE_DA-1:0] m4_side;

    ehr_mul #(.AW(RW), .BW(AW), .SW(SIDE_DA)) u_mul_b (
        .clk(clk), .rst_n(rst_n), .en(advance), .in_v(m3_v),
        .a(polar_radius_reg), .b(m3_side[AW-1:0]),
        .side_in({m3_side[SIDE_DX-1:AW], m3_p[RW+AW-1:10]}),
        .out_v(m4_v), .p(m4_p), .side_out(m4_side)
    );

    // a squared
    logic               m5_v;
    logic [SQ_W-1:0]    m5_p;
    logic [SIDE_DA-1:0] m5_side;

    ehr_mul #(.AW(AB_W), .BW(AB_W), .SW(SIDE_DA)) u_mul_aa (
        .clk(clk), .rst_n(rst_n), .en(advance), .in_v(m4_v),
        .a(m4_side[AB_W-1:0]), .b(m4_side[AB_W-1:0]),
        .side_in({m4_side[SIDE_DA-1:AB_W], m4_p[RW+AW-1:10]}),
        .out_v(m5_v), .p(m5_p), .side_out(m5_side)
    );

    // b squared
    logic               m6_v;
    logic [SQ_W-1:0]    m6_p;
    logic [SIDE_DS-1:0] m6_side;

    ehr_mul #(.AW(AB_W), .BW(AB_W), .SW(SIDE_DS)) u_mul_bb (
        .clk(clk), .rst_n(rst_n), .en(advance), .in_v(m5_v),
        .a(m5_side[AB_W-1:0]), .b(m5_side[AB_W-1:0]),
        .side_in({m5_side[SIDE_DA-1:AB_W], m5_p}),
        .out_v(m6_v), .p(m6_p), .side_out(m6_side)
    );

    // sum of squares
    logic          sum_v_reg;
    logic [DW-1:0] sum_dist_reg;
    logic [N_W-1:0] sum_n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            sum_v_reg <= m6_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sum_dist_reg <= m6_side[SIDE_DS-1:SQ_W];
            sum_n_reg    <= N_W'(m6_side[SQ_W-1:0]) + N_W'(m6_p);
        end
    end

    // p * e for the numerator, alongside the sum
    logic               m7_v;
    logic [PE_W-1:0]    m7_p;
    logic [SIDE_DN-1:0] m7_side;

    ehr_mul #(.AW(RW), .BW(RW), .SW(SIDE_DN)) u_mul_pe (
        .clk(clk), .rst_n(rst_n), .en(advance), .in_v(sum_v_reg),
        .a(equatorial_radius_reg), .b(polar_radius_reg),
        .side_in({sum_dist_reg, sum_n_reg}),
        .out_v(m7_v), .p(m7_p), .side_out(m7_side)
    );

    // square root row; side carries distance and p * e
    logic                       rv    [STEPS+1];
    logic [ehr_pkg::ROOT_W-1:0] rrem  [STEPS+1];
    logic [ehr_pkg::ROOT_W-1:0] rroot [STEPS+1];
    logic [SIDE_DP-1:0]         rside [STEPS+1];

    assign rv[0]    = m7_v;
    assign rrem[0]  = ehr_pkg::ROOT_W'(m7_side[N_W-1:0]);
    assign rroot[0] = '0;
    assign rside[0] = {m7_side[SIDE_DN-1:N_W], m7_p};

    for (genvar i = 0; i < STEPS; i++)
    begin : g_root
        ehr_root_cell #(.BITPOS(STEPS - 1 - i), .SW(SIDE_DP)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(advance), .in_v(rv[i]),
            .rem_in(rrem[i]), .root_in(rroot[i]), .side_in(rside[i]),
            .out_v(rv[i+1]), .rem_out(rrem[i+1]), .root_out(rroot[i+1]),
            .side_out(rside[i+1])
        );
    end

    // divider setup: numerator p*e*2^20, quotient overflow and zero norm flags
    logic [ehr_pkg::NORM_W-1:0]    norm;
    logic [ehr_pkg::DIV_REM_W-1:0] num, dtop;
    logic                          prep_v_reg;
    logic [ehr_pkg::DIV_REM_W-1:0] prep_rem_reg;
    logic [ehr_pkg::NORM_W-1:0]    prep_d_reg;
    logic [DW-1:0]                 prep_dist_reg;
    logic                          prep_zero_reg;
    logic                          prep_ovf_reg;

    always_comb
    begin
        norm = rroot[STEPS][ehr_pkg::NORM_W-1:0];
        num  = ehr_pkg::DIV_REM_W'(rside[STEPS][PE_W-1:0]) << 20;
        dtop = ehr_pkg::DIV_REM_W'(norm) << QW;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            prep_v_reg <= rv[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prep_rem_reg  <= num;
            prep_d_reg    <= norm;
            prep_dist_reg <= rside[STEPS][SIDE_DP-1:PE_W];
            prep_zero_reg <= (norm == '0);
            prep_ovf_reg  <= (num >= dtop);
        end
    end

    // divider row, top quotient bit first; side carries distance and flags
    logic                          dv    [QW+1];
    logic [ehr_pkg::DIV_REM_W-1:0] drem  [QW+1];
    logic [ehr_pkg::NORM_W-1:0]    dd    [QW+1];
    logic [QW-1:0]                 dq    [QW+1];
    logic [SIDE_DIV-1:0]           dside [QW+1];

    assign dv[0]    = prep_v_reg;
    assign drem[0]  = prep_rem_reg;
    assign dd[0]    = prep_d_reg;
    assign dq[0]    = '0;
    assign dside[0] = {prep_dist_reg, prep_zero_reg, prep_ovf_reg};

    for (genvar i = 0; i < QW; i++)
    begin : g_div
        ehr_div_cell #(.J(QW - 1 - i), .SW(SIDE_DIV)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(advance), .in_v(dv[i]),
            .rem_in(drem[i]), .d_in(dd[i]), .q_in(dq[i]), .side_in(dside[i]),
            .out_v(dv[i+1]), .rem_out(drem[i+1]), .d_out(dd[i+1]), .q_out(dq[i+1]),
            .side_out(dside[i+1])
        );
    end

    // radius cap, subtraction and saturation
    logic [QW-1:0]          radius;
    logic signed [HW+1:0]   diff;
    logic [HW-1:0]          h_next;
    logic                   fin_v_reg;
    logic [HW-1:0]          fin_h_reg;

    always_comb
    begin
        if (dside[QW][1])
        begin
            radius = '0;
        end
        else if (dside[QW][0] || (dq[QW] > ehr_pkg::RADIUS_CAP))
        begin
            radius = ehr_pkg::RADIUS_CAP;
        end
        else
        begin
            radius = dq[QW];
        end
        diff = $signed({3'b000, dside[QW][SIDE_DIV-1:2]}) - $signed({1'b0, radius});
        if (diff < NegLimit)
        begin
            h_next = NegLimit[HW-1:0];
        end
        else if (diff > PosLimit)
        begin
            h_next = PosLimit[HW-1:0];
        end
        else
        begin
            h_next = diff[HW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            fin_v_reg <= dv[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fin_h_reg <= h_next;
        end
    end

    // output register with one skid entry behind it
    logic          out_valid_reg;
    logic [HW-1:0] out_h_reg;
    logic [HW-1:0] skid_h_reg;
    logic          out_take;
    logic          pipe_out;

    assign out_take = out_valid_reg && !out_stall;
    assign pipe_out = fin_v_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (pipe_out)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_h_reg <= skid_h_reg;
            end
        end
        else if (pipe_out)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_h_reg <= fin_h_reg;
            end
            else
            begin
                skid_h_reg <= fin_h_reg;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign ellipsoid_height = out_h_reg;

`ifndef SYNTHESIS
    // skid entry only fills behind a waiting result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without an output result");

    // a taken result drains the skid entry at once
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_stall) |=> !skid_valid_reg)
        else $error("skid entry not drained after output taken");

    // a result leaving the pipe into a blocked output lands in the skid entry
    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (pipe_out && out_valid_reg && out_stall) |=> skid_valid_reg)
        else $error("result dropped at blocked output");

    // saturation never lets the most negative code out
    a_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_h_reg != {1'b1, {(HW-1){1'b0}}}))
        else $error("height outside saturation range");
`endif

endmodule

`default_nettype wire
